// ----- rtl/core/ai128_pkg.sv -----
// Package for the ASCII integer parser: phase, base and status codes,
// character constants and the digit decoder.
// No dependencies.
package ai128_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_MODE   = 2'd1;

  // base_mode register codes; any other code means automatic
  localparam logic [1:0] BM_AUTO = 2'd0;
  localparam logic [1:0] BM_HEX  = 2'd1;
  localparam logic [1:0] BM_OCT  = 2'd2;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LX    = 8'h78;

  typedef enum logic [4:0] {
    PH_SKIP = 5'b00001,
    PH_SIGN = 5'b00010,
    PH_ZERO = 5'b00100,
    PH_X    = 5'b01000,
    PH_DIG  = 5'b10000
  } phase_e;

  typedef enum logic [1:0] {
    NB_DEC = 2'd0,
    NB_HEX = 2'd1,
    NB_OCT = 2'd2
  } nbase_e;

  typedef enum logic [2:0] {
    ST_RUN      = 3'd0,
    ST_OK       = 3'd1,
    ST_OVERFLOW = 3'd2,
    ST_BAD      = 3'd3,
    ST_NO_SIGN  = 3'd4,
    ST_EARLY    = 3'd5
  } status_e;

  typedef struct packed {
    logic       valid;
    logic [3:0] val;
  } digit_t;

  function automatic digit_t digit_of(logic [7:0] c, nbase_e nb);
    digit_t     r;
    logic [4:0] d;
    logic [4:0] lim;
    logic       hit;
    hit = 1'b1;
    d   = 5'd0;
    if (c inside {[CH_ZERO:CH_NINE]}) begin
      d = 5'(c - CH_ZERO);
    end else if (c inside {[CH_LA:CH_LF]}) begin
      d = 5'(c - CH_LA) + 5'd10;
    end else if (c inside {[CH_UA:CH_UF]}) begin
      d = 5'(c - CH_UA) + 5'd10;
    end else begin
      hit = 1'b0;
    end
    case (nb)
      NB_HEX:  lim = 5'd16;
      NB_OCT:  lim = 5'd8;
      default: lim = 5'd10;
    endcase
    r.valid = hit && (d < lim);
    r.val   = d[3:0];
    return r;
  endfunction

endpackage

// ----- rtl/core/ai128_in_if.sv -----
// Input channel of the ASCII integer parser: one text byte per item.
// Depends on nothing.
interface ai128_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_text;

  modport source (output valid, output ch, output end_of_text, input ready);
  modport sink   (input valid, input ch, input end_of_text, output ready);
endinterface

// ----- rtl/core/ai128_out_if.sv -----
// Result channel of the ASCII integer parser: one status item per input byte.
// Depends on nothing.
interface ai128_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] value_hi;
  logic [63:0] value_lo;
  logic        pushed_back;

  modport source (output valid, output status, output value_hi, output value_lo,
                  output pushed_back, input ready);
  modport sink   (input valid, input status, input value_hi, input value_lo,
                  input pushed_back, output ready);
endinterface

// ----- rtl/core/ai128_mac.sv -----
// Digit accumulate for the parser: acc * base + digit by shifts and adds,
// with a range check against the signed or unsigned limit. Uses ai128_pkg.
module ai128_mac import ai128_pkg::*; #(
  parameter int unsigned VALUE_BITS = 128
) (
  input  logic [VALUE_BITS-1:0] acc_i,
  input  nbase_e                base_i,
  input  logic [3:0]            digit_i,
  input  logic                  neg_i,
  input  logic                  signed_mode_i,
  output logic [VALUE_BITS-1:0] sum_o,
  output logic                  fits_o
);

  // four spare bits hold any product before the range check
  localparam int unsigned W = VALUE_BITS + 4;

  logic [W-1:0] wide;
  logic [W-1:0] prod;
  logic [W-1:0] lim;

  assign wide = W'(acc_i);

  always_comb begin
    case (base_i)
      NB_HEX:  prod = (wide << 4);
      NB_OCT:  prod = (wide << 3);
      default: prod = (wide << 3) + (wide << 1);
    endcase
    prod = prod + W'(digit_i);
  end

  always_comb begin
    if (neg_i) begin
      lim = W'(1) << (VALUE_BITS - 1);
    end else if (signed_mode_i) begin
      lim = (W'(1) << (VALUE_BITS - 1)) - W'(1);
    end else begin
      lim = (W'(1) << VALUE_BITS) - W'(1);
    end
  end

  assign fits_o = (prod <= lim);
  assign sum_o  = prod[VALUE_BITS-1:0];

endmodule

// ----- rtl/core/ascii_int128_parser.sv -----
// ASCII integer parser, top level.
// Uses ai128_pkg, ai128_in_if, ai128_out_if and ai128_mac.
//
// Feed text on in_ch one byte per item; set end_of_text on the item that
// closes the text. Every accepted item yields exactly one result on out_ch:
// a status, the value so far (two's complement, sign-extended to 128 bits,
// split in value_hi/value_lo) and pushed_back. A result with pushed_back set
// means the byte was not used: send it again as the first byte of what follows.
// After any final status (ok, overflow, bad digit, sign refused, early end)
// the parser starts over on the next number.
// The result is registered and valid in the cycle after accept; one item is
// taken every cycle unless out_ch stalls. Per byte, the accumulator shift-add
// (x8, x10 or x16 plus digit) and its limit compare update the parse state.
// When out_ch stalls the result holds; in_ch.ready stays high while the
// result register is empty or being taken in the same cycle.
// The user must make configuration writes (signed_mode at index 0, base_mode at
// index 1) while the block is idle; it does not enforce this. Reset clears the
// parse state and pending result, loads signed_mode = 1, base_mode = automatic.
module ascii_int128_parser import ai128_pkg::*; #(
  parameter int unsigned VALUE_BITS = 128
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ai128_in_if.sink              in_ch,
  ai128_out_if.source           out_ch,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  logic                  sm_q;
  logic [1:0]            bm_q;
  phase_e                ph_q, ph_d;
  logic                  neg_q, neg_d;
  nbase_e                nb_q, nb_d;
  logic [VALUE_BITS-1:0] acc_q, acc_d;

  logic                  ov_q;
  status_e               status_q, status_d;
  logic [127:0]          val_q, val_d;
  logic                  pb_q, pb_d;

  logic                  accept;
  logic [7:0]            c;
  logic                  eot;
  nbase_e                mac_nb;
  digit_t                md;
  logic [VALUE_BITS-1:0] mac_sum;
  logic                  mac_fits;

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = !ov_q || out_ch.ready;
  assign c            = in_ch.ch;
  assign eot          = in_ch.end_of_text;

  // after a lone zero the next byte, unless x or X, is decoded as an octal digit
  assign mac_nb = (ph_q == PH_ZERO) ? NB_OCT : nb_q;
  assign md     = digit_of(c, mac_nb);

  ai128_mac #(
    .VALUE_BITS (VALUE_BITS)
  ) u_mac (
    .acc_i         (acc_q),
    .base_i        (mac_nb),
    .digit_i       (md.val),
    .neg_i         (neg_q),
    .signed_mode_i (sm_q),
    .sum_o         (mac_sum),
    .fits_o        (mac_fits)
  );

  always_comb begin
    logic          start;
    logic          first;
    logic          dstep;
    nbase_e        first_nb;
    digit_t        fd;
    logic [127:0]  ext;
    ph_d     = ph_q;
    neg_d    = neg_q;
    nb_d     = nb_q;
    acc_d    = acc_q;
    status_d = ST_RUN;
    pb_d     = 1'b0;
    start    = 1'b0;
    first    = 1'b0;
    dstep    = 1'b0;
    first_nb = NB_DEC;

    case (ph_q)
      PH_SIGN: begin
        if (eot) status_d = ST_EARLY;
        else     start = 1'b1;
      end
      PH_ZERO: begin
        if (eot) begin
          status_d = ST_OK;
        end else if (c == CH_LX || c == CH_UX) begin
          nb_d = NB_HEX;
          ph_d = PH_X;
        end else begin
          nb_d  = NB_OCT;
          ph_d  = PH_DIG;
          dstep = 1'b1;
        end
      end
      PH_X: begin
        if (eot) begin
          status_d = ST_EARLY;
        end else begin
          first    = 1'b1;
          first_nb = NB_HEX;
        end
      end
      PH_DIG: begin
        dstep = 1'b1;
      end
      default: begin
        ph_d = PH_SKIP;
        if (eot) begin
          status_d = ST_EARLY;
        end else if (c == CH_SPACE || c inside {[CH_TAB:CH_CR]}) begin
          // skip whitespace
        end else if (c == CH_MINUS) begin
          if (!sm_q) begin
            status_d = ST_NO_SIGN;
            pb_d     = 1'b1;
          end else begin
            neg_d = 1'b1;
            ph_d  = PH_SIGN;
          end
        end else if (c == CH_PLUS) begin
          ph_d = PH_SIGN;
        end else begin
          start = 1'b1;
        end
      end
    endcase

    if (start) begin
      case (bm_q)
        BM_HEX: begin
          first    = 1'b1;
          first_nb = NB_HEX;
        end
        BM_OCT: begin
          first    = 1'b1;
          first_nb = NB_OCT;
        end
        default: begin
          if (c == CH_ZERO) begin
            ph_d = PH_ZERO;
          end else begin
            first    = 1'b1;
            first_nb = NB_DEC;
          end
        end
      endcase
    end

    fd = digit_of(c, first_nb);
    if (first) begin
      nb_d = first_nb;
      if (!fd.valid) begin
        status_d = ST_BAD;
        pb_d     = 1'b1;
      end else begin
        acc_d = VALUE_BITS'(fd.val);
        ph_d  = PH_DIG;
      end
    end

    if (dstep) begin
      if (eot) begin
        status_d = ST_OK;
      end else if (!md.valid) begin
        status_d = ST_OK;
        pb_d     = 1'b1;
      end else if (!mac_fits) begin
        // keep the last value that fitted
        status_d = ST_OVERFLOW;
      end else begin
        acc_d = mac_sum;
      end
    end

    ext = 128'(acc_d);
    if (neg_d) ext = ~ext + 128'd1;
    if (status_d == ST_BAD || status_d == ST_NO_SIGN || status_d == ST_EARLY) begin
      ext = '0;
    end
    val_d = ext;

    if (status_d != ST_RUN) begin
      ph_d  = PH_SKIP;
      neg_d = 1'b0;
      nb_d  = NB_DEC;
      acc_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sm_q <= 1'b1;
      bm_q <= BM_AUTO;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_SIGNED_MODE) sm_q <= cfg_wdata_i[0];
      if (cfg_idx_i == REG_BASE_MODE)   bm_q <= cfg_wdata_i[1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= PH_SKIP;
      neg_q <= 1'b0;
      nb_q  <= NB_DEC;
      acc_q <= '0;
    end else if (accept) begin
      ph_q  <= ph_d;
      neg_q <= neg_d;
      nb_q  <= nb_d;
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (accept) begin
      ov_q <= 1'b1;
    end else if (out_ch.ready) begin
      ov_q <= 1'b0;
    end
  end

  // result payload loads only on accept, so it holds while stalled
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      val_q    <= val_d;
      pb_q     <= pb_d;
    end
  end

  assign out_ch.valid       = ov_q;
  assign out_ch.status      = status_q;
  assign out_ch.value_hi    = val_q[127:64];
  assign out_ch.value_lo    = val_q[63:0];
  assign out_ch.pushed_back = pb_q;

endmodule

// ----- rtl/core/ai128_chk.sv -----
// Port-level checks for the ASCII integer parser, bound to the top level.
// Uses ai128_pkg; attaches to ascii_int128_parser.
module ai128_chk import ai128_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  status_i,
  input logic [63:0] value_hi_i,
  input logic [63:0] value_lo_i,
  input logic        pushed_back_i
);

  // hold the result while the receiver stalls
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i)
      && $stable(value_hi_i) && $stable(value_lo_i) && $stable(pushed_back_i))
    else $error("result changed while stalled");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("accepted item gave no result");

  a_zero_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_BAD || status_i == ST_NO_SIGN || status_i == ST_EARLY)
      |-> value_hi_i == 64'd0 && value_lo_i == 64'd0)
    else $error("nonzero value with error status");

  a_pushback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && pushed_back_i |-> status_i == ST_OK || status_i == ST_BAD
      || status_i == ST_NO_SIGN)
    else $error("push-back with wrong status");

endmodule

bind ascii_int128_parser ai128_chk u_ai128_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_ch.valid),
  .in_ready_i    (in_ch.ready),
  .out_valid_i   (out_ch.valid),
  .out_ready_i   (out_ch.ready),
  .status_i      (out_ch.status),
  .value_hi_i    (out_ch.value_hi),
  .value_lo_i    (out_ch.value_lo),
  .pushed_back_i (out_ch.pushed_back)
);

// ----- tb/tb_ascii_int128_parser.sv -----
// Testbench for ascii_int128_parser: drives text bytes through the input channel,
// predicts every status item with its own parser model and checks the result channel.
// Depends on ai128_pkg, ai128_in_if, ai128_out_if and the parser RTL.
module tb_ascii_int128_parser;
  timeunit 1ns;
  timeprecision 1ps;
  import ai128_pkg::*;

  localparam int unsigned VALUE_BITS   = 128;
  localparam int unsigned RESET_CYCLES = 10;
  localparam int unsigned QUIET_LIMIT  = 1000;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned PHASE_ITEMS  = 100;
  localparam logic [1:0]  BM_UNUSED    = 2'd3;
  localparam logic [7:0]  CH_LFEED     = 8'h0a;
  localparam logic [7:0]  CH_VTAB      = 8'h0b;
  localparam logic [7:0]  CH_FFEED     = 8'h0c;
  localparam logic [7:0]  CH_COMMA     = 8'h2c;

  typedef struct packed {
    status_e     status;
    logic [63:0] value_hi;
    logic [63:0] value_lo;
    logic        pushed_back;
  } parse_result_t;

  class parse_scoreboard;
    bit            signed_mode;
    logic [1:0]    base_mode;
    phase_e        phase;
    bit            negative;
    nbase_e        radix;
    logic [127:0]  magnitude;
    parse_result_t expected_q[$];
    int unsigned   errors;

    function new();
      signed_mode = 1'b1;
      base_mode   = BM_AUTO;
      errors      = 0;
      clear_number();
    endfunction

    function void clear_number();
      phase     = PH_SKIP;
      negative  = 1'b0;
      radix     = NB_DEC;
      magnitude = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_SIGNED_MODE) begin
        signed_mode = data[0];
      end else if (idx == REG_BASE_MODE) begin
        base_mode = data;
      end
    endfunction

    function int unsigned radix_value(nbase_e nb);
      case (nb)
        NB_HEX:  return 16;
        NB_OCT:  return 8;
        default: return 10;
      endcase
    endfunction

    function int digit_value(logic [7:0] c, nbase_e nb);
      int d;
      if (c >= CH_ZERO && c <= CH_NINE) begin
        d = int'(c) - int'(CH_ZERO);
      end else if (c >= CH_LA && c <= CH_LF) begin
        d = int'(c) - int'(CH_LA) + 10;
      end else if (c >= CH_UA && c <= CH_UF) begin
        d = int'(c) - int'(CH_UA) + 10;
      end else begin
        return -1;
      end
      return (d < int'(radix_value(nb))) ? d : -1;
    endfunction

    function void push_result(status_e st, bit pb);
      parse_result_t r;
      logic [127:0]  v;
      v = '0;
      if (st == ST_RUN || st == ST_OK || st == ST_OVERFLOW) begin
        v = negative ? -magnitude : magnitude;
      end
      r.status      = st;
      r.value_hi    = v[127:64];
      r.value_lo    = v[63:0];
      r.pushed_back = pb;
      expected_q.push_back(r);
      if (st != ST_RUN) clear_number();
    endfunction

    // multiply-add, kept only when it stays inside the range for the sign and mode
    function bit grow(int unsigned base, int d);
      logic [131:0] t;
      logic [131:0] lim;
      t = {4'b0, magnitude} * 132'(base) + 132'(d);
      if (negative) begin
        lim = 132'(1) << (VALUE_BITS - 1);
      end else if (signed_mode) begin
        lim = (132'(1) << (VALUE_BITS - 1)) - 132'(1);
      end else begin
        lim = (132'(1) << VALUE_BITS) - 132'(1);
      end
      if (t > lim) return 1'b0;
      magnitude = t[127:0];
      return 1'b1;
    endfunction

    function void first_digit(logic [7:0] c, nbase_e nb);
      int d;
      radix = nb;
      d = digit_value(c, nb);
      if (d < 0) begin
        push_result(ST_BAD, 1'b1);
      end else begin
        magnitude = 128'(d);
        phase     = PH_DIG;
        push_result(ST_RUN, 1'b0);
      end
    endfunction

    function void start_number(logic [7:0] c);
      if (base_mode == BM_HEX) begin
        first_digit(c, NB_HEX);
      end else if (base_mode == BM_OCT) begin
        first_digit(c, NB_OCT);
      end else if (c == CH_ZERO) begin
        phase = PH_ZERO;
        push_result(ST_RUN, 1'b0);
      end else begin
        first_digit(c, NB_DEC);
      end
    endfunction

    function void digit_step(logic [7:0] c, bit eot);
      int d;
      if (eot) begin
        push_result(ST_OK, 1'b0);
        return;
      end
      d = digit_value(c, radix);
      if (d < 0) begin
        push_result(ST_OK, 1'b1);
      end else if (!grow(radix_value(radix), d)) begin
        push_result(ST_OVERFLOW, 1'b0);
      end else begin
        push_result(ST_RUN, 1'b0);
      end
    endfunction

    function void note_input(logic [7:0] c, bit eot);
      case (phase)
        PH_SIGN: begin
          if (eot) push_result(ST_EARLY, 1'b0);
          else start_number(c);
        end
        PH_ZERO: begin
          if (eot) begin
            push_result(ST_OK, 1'b0);
          end else if (c == CH_LX || c == CH_UX) begin
            radix = NB_HEX;
            phase = PH_X;
            push_result(ST_RUN, 1'b0);
          end else begin
            // leading zero means octal; this byte is its first digit
            radix = NB_OCT;
            phase = PH_DIG;
            digit_step(c, 1'b0);
          end
        end
        PH_X: begin
          if (eot) push_result(ST_EARLY, 1'b0);
          else first_digit(c, NB_HEX);
        end
        PH_DIG: digit_step(c, eot);
        default: begin
          phase = PH_SKIP;
          if (eot) begin
            push_result(ST_EARLY, 1'b0);
          end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
            push_result(ST_RUN, 1'b0);
          end else if (c == CH_MINUS) begin
            if (!signed_mode) begin
              push_result(ST_NO_SIGN, 1'b1);
            end else begin
              negative = 1'b1;
              phase    = PH_SIGN;
              push_result(ST_RUN, 1'b0);
            end
          end else if (c == CH_PLUS) begin
            phase = PH_SIGN;
            push_result(ST_RUN, 1'b0);
          end else begin
            start_number(c);
          end
        end
      endcase
    endfunction

    function void check_result(logic [2:0] st, logic [63:0] hi, logic [63:0] lo, logic pb);
      parse_result_t e;
      if (expected_q.size() == 0) begin
        $error("result with no item pending: status %0d", st);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        errors++;
      end
      if (hi !== e.value_hi) begin
        $error("value_hi: expected %h, got %h", e.value_hi, hi);
        errors++;
      end
      if (lo !== e.value_lo) begin
        $error("value_lo: expected %h, got %h", e.value_lo, lo);
        errors++;
      end
      if (pb !== e.pushed_back) begin
        $error("pushed_back: expected %0d, got %0d", e.pushed_back, pb);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ai128_in_if  in_ch ();
  ai128_out_if out_ch ();

  ascii_int128_parser #(.VALUE_BITS(VALUE_BITS)) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  parse_scoreboard sb;
  int unsigned     send_idle_pct;
  int unsigned     recv_stall_pct;
  int unsigned     hold_left;
  bit              hold_req;
  logic [1:0]      cur_base_mode;
  logic [8:0]      text_q[$];   // {end_of_text, ch}
  int unsigned     sent_count;
  int unsigned     quiet_cycles;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      out_ch.ready = 1'b0;
      hold_left--;
    end else begin
      out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result(out_ch.status, out_ch.value_hi, out_ch.value_lo, out_ch.pushed_back);
      end
      if (in_ch.valid && in_ch.ready) begin
        sb.note_input(in_ch.ch, in_ch.end_of_text);
      end
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] c, input bit eot);
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid       = 1'b0;
      in_ch.ch          = 8'($urandom);
      in_ch.end_of_text = 1'($urandom);
      @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.ch          = c;
    in_ch.end_of_text = eot;
    do @(posedge clk); while (!in_ch.ready);
    sent_count++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic send_end();
    send_byte(8'($urandom), 1'b1);
  endtask

  task automatic flush_text();
    logic [8:0] e;
    while (text_q.size() != 0) begin
      e = text_q.pop_front();
      send_byte(e[7:0], e[8]);
    end
  endtask

  // hold the sender until every pending result is back
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = data;
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_mode(input bit sm, input logic [1:0] bm);
    drain();
    write_reg(REG_SIGNED_MODE, {1'b0, sm});
    write_reg(REG_BASE_MODE, bm);
    cur_base_mode = bm;
  endtask

  function automatic logic [7:0] digit_char(int unsigned d);
    if (d < 10) return 8'(CH_ZERO + d);
    return 8'(($urandom_range(1) ? CH_LA : CH_UA) + d - 10);
  endfunction

  task automatic push_digits(input logic [127:0] v, input int unsigned base);
    logic [7:0]   digits[$];
    logic [127:0] rest;
    rest = v;
    do begin
      digits.push_front(digit_char(int'(rest % 128'(base))));
      rest = rest / 128'(base);
    end while (rest != 0);
    foreach (digits[i]) text_q.push_back({1'b0, digits[i]});
  endtask

  // well-formed number text: spaces, sign, prefix, digits, terminator
  task automatic gen_number();
    logic [7:0]   spaces[6];
    int unsigned  base;
    int unsigned  kind;
    logic [127:0] v;
    logic [7:0]   term;
    spaces = '{CH_SPACE, CH_TAB, CH_LFEED, CH_VTAB, CH_FFEED, CH_CR};
    repeat ($urandom_range(2)) text_q.push_back({1'b0, spaces[$urandom_range(5)]});
    case ($urandom_range(3))
      0:       text_q.push_back({1'b0, CH_PLUS});
      1:       text_q.push_back({1'b0, CH_MINUS});
      default: ;
    endcase
    if (cur_base_mode == BM_HEX) begin
      base = 16;
    end else if (cur_base_mode == BM_OCT) begin
      base = 8;
    end else begin
      case ($urandom_range(3))
        0: begin
          text_q.push_back({1'b0, CH_ZERO});
          text_q.push_back({1'b0, $urandom_range(1) ? CH_LX : CH_UX});
          base = 16;
        end
        1: begin
          text_q.push_back({1'b0, CH_ZERO});
          base = 8;
        end
        default: base = 10;
      endcase
    end
    kind = $urandom_range(9);
    case (kind)
      0, 1:    v = (128'(1) << (VALUE_BITS - 1)) + 128'($urandom_range(2)) - 128'(1);
      2:       v = '1 - 128'($urandom_range(1));
      3:       v = {$urandom, $urandom, $urandom, $urandom};
      4:       v = {64'd0, $urandom, $urandom};
      default: v = 128'($urandom_range(99999));
    endcase
    push_digits(v, base);
    // one more digit drives the extremes past the range
    if ($urandom_range(3) == 0) text_q.push_back({1'b0, digit_char($urandom_range(base - 1))});
    case ($urandom_range(4))
      0, 1:    term = '0;
      2:       term = CH_SPACE;
      3:       term = 8'($urandom);
      default: term = CH_COMMA;
    endcase
    if (term == '0 && $urandom_range(4) != 0) begin
      text_q.push_back({1'b1, 8'($urandom)});
    end else begin
      text_q.push_back({1'b0, term});
      // resend the pushed-back terminator
      if ($urandom_range(1)) text_q.push_back({1'b0, term});
    end
  endtask

  task automatic gen_noise();
    repeat ($urandom_range(1, 3)) text_q.push_back({($urandom_range(7) == 0), 8'($urandom)});
  endtask

  initial begin
    bit          sm_list[8];
    logic [1:0]  bm_list[8];
    int unsigned target;
    int unsigned mid;
    bit          paused;
    sm_list = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    bm_list = '{BM_AUTO, BM_AUTO, BM_HEX, BM_OCT, BM_UNUSED, BM_HEX, BM_OCT, BM_AUTO};
    sb                = new();
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.ch          = '0;
    in_ch.end_of_text = 1'b0;
    out_ch.ready      = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = '0;
    cfg_wdata         = '0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    hold_left         = 0;
    hold_req          = 1'b0;
    cur_base_mode     = BM_AUTO;
    sent_count        = 0;
    quiet_cycles      = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // directed text under the reset settings
    send_end();                      // end while skipping
    send_text("0");   send_end();    // lone zero
    send_text("+");   send_end();    // end after a sign
    send_text("0x");  send_end();    // end after the hex prefix
    send_text("0Xg");                // non-hex byte after the prefix
    send_text("-+");                 // sign after a sign
    send_text("\t017 ");             // octal, terminator pushed back
    send_byte(8'hff, 1'b0);          // high byte is no digit
    send_byte(8'h00, 1'b0);
    send_text("-9,");

    for (int p = 0; p < 8; p++) begin
      set_mode(sm_list[p], bm_list[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      if (!sm_list[p]) send_text("--");   // refused minus, then resent
      if (p == 0) hold_req = 1'b1;
      target = sent_count + PHASE_ITEMS;
      mid    = sent_count + PHASE_ITEMS / 2;
      paused = 1'b0;
      while (sent_count < target) begin
        if (!paused && sent_count >= mid) begin
          drain();
          paused = 1'b1;
        end
        if ($urandom_range(99) < 15) gen_noise();
        else gen_number();
        flush_text();
      end
    end

    drain();
    repeat (5) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
